/* hw/rtl/gte_pkg.sv */
// ----------------------------------------------------------------------------
// gte_pkg
// Shared constants, types and helpers of the tiled matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

    localparam int MAX_DIM      = 64;
    localparam int TILE         = 8;
    localparam int GAIN_SHIFT   = 8;
    localparam int DIM_W        = $clog2(MAX_DIM);
    localparam int TILE_W       = $clog2(TILE);
    localparam int TILES        = MAX_DIM / TILE;
    localparam int TIDX_W       = $clog2(TILES);
    localparam int ADDR_W       = 2 * DIM_W;
    localparam int BANK_ADDR_W  = DIM_W + TIDX_W;
    localparam int KK_W         = DIM_W + 1;
    localparam int ELEM_W       = 16;
    localparam int CELEM_W      = 32;
    localparam int ACC_W        = 2 * ELEM_W + DIM_W;
    localparam int CFG_IDX_W    = 3;
    localparam int FLUSH_CYCLES = TILE + 4;
    localparam int FLUSH_W      = $clog2(FLUSH_CYCLES);

    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_LOAD_C  = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_TILES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_TILES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER     = 3'd4;

    typedef struct packed {
        logic                     vld;
        logic signed [ELEM_W-1:0] a;
        logic [DIM_W-1:0]         k;
    } t_tok;

    function automatic logic signed [ELEM_W-1:0] sat16(input logic signed [31:0] v);
        logic signed [ELEM_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[ELEM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gemm_tile_engine_core.sv */
// ----------------------------------------------------------------------------
// gemm_tile_engine_core
// Tiled matrix multiply C = alpha*A*B + beta*C on a chain of MAC cells.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | word
//  in       | in        | i_in_valid / o_in_stall  | req_type, row, col, value
//  out      | out       | o_out_valid / i_out_stall| out_row, out_col, result, last, status
//  cfg      | in        | i_cfg_valid / o_cfg_ready| register index, data
//
//  A load is accepted whenever the core is idle. A compute tile runs, per
//  tile row, A reads into the cell chain, a chain flush and then, for each
//  result, the read, multiply and output steps of the scaling unit.
//  An out-of-range tile gives one error word. Reset is synchronous; the
//  element stores are not cleared. Output stalls hold the scaling unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gemm_tile_engine_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [1:0]                            i_req_type,
    input  wire logic [5:0]                            i_row,
    input  wire logic [5:0]                            i_col,
    input  wire logic signed [31:0]                    i_value,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [5:0]                                 o_out_row,
    output logic [5:0]                                 o_out_col,
    output logic signed [31:0]                         o_result,
    output logic                                       o_last,
    output logic                                       o_status,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [gte_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [31:0]                           i_cfg_data
);
    import gte_pkg::*;

    localparam int PA_W  = ACC_W + ELEM_W;
    localparam int PB_W  = CELEM_W + ELEM_W;
    localparam int SUM_W = PA_W - GAIN_SHIFT + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_FEED, S_FLUSH, S_EPI_RD, S_EPI_MUL, S_EPI_OUT, S_ERR
    } t_state;

    t_state                    r_state;
    logic signed [ELEM_W-1:0]  r_alpha, r_beta;
    logic [3:0]                r_row_tiles, r_col_tiles;
    logic [KK_W-1:0]           r_inner;
    logic [TIDX_W-1:0]         r_trow, r_tcol;
    logic [TILE_W-1:0]         r_i, r_j;
    logic [KK_W-1:0]           r_k;
    logic [FLUSH_W-1:0]        r_cnt;
    logic                      r_feed_q;
    logic [DIM_W-1:0]          r_k_q;
    logic signed [ELEM_W-1:0]  r_a_q;
    logic signed [CELEM_W-1:0] r_c_q;
    logic signed [ACC_W-1:0]   r_acc_q;
    logic signed [PA_W-1:0]    r_pa;
    logic signed [PB_W-1:0]    r_pb;
    logic                      r_out_valid;

    logic signed [ELEM_W-1:0]  r_a_mem [MAX_DIM*MAX_DIM];
    logic signed [CELEM_W-1:0] r_c_mem [MAX_DIM*MAX_DIM];

    t_tok                      w_tok [TILE+1];
    logic signed [ACC_W-1:0]   w_acc [TILE+1];

    logic                      in_acc, out_free, clear, shift, emit;
    logic [3:0]                rt, ct;
    logic [KK_W-1:0]           kk;
    logic [ADDR_W-1:0]         c_addr;
    logic signed [SUM_W-1:0]   t_a, t_b, sum;
    logic signed [CELEM_W-1:0] sat_sum;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit   = ((r_state == S_EPI_OUT) || (r_state == S_ERR)) && out_free;
    assign rt = (r_row_tiles > 4'(TILES)) ? 4'(TILES) : r_row_tiles;
    assign ct = (r_col_tiles > 4'(TILES)) ? 4'(TILES) : r_col_tiles;
    assign kk = (r_inner > KK_W'(MAX_DIM)) ? KK_W'(MAX_DIM) : r_inner;
    assign c_addr = {r_trow, r_i, r_tcol, r_j};
    assign clear  = in_acc && (i_req_type == REQ_COMPUTE);
    assign shift  = (r_state == S_EPI_RD);

    assign t_a = SUM_W'(r_pa >>> GAIN_SHIFT);
    assign t_b = SUM_W'(r_pb >>> GAIN_SHIFT);
    assign sum = t_a + t_b;
    always_comb begin
        if (sum > SUM_W'(32'sh7fffffff)) begin
            sat_sum = 32'sh7fffffff;
        end else if (sum < -SUM_W'(33'sh080000000)) begin
            sat_sum = 32'sh80000000;
        end else begin
            sat_sum = sum[CELEM_W-1:0];
        end
    end

    assign w_tok[0].vld = r_feed_q;
    assign w_tok[0].a   = r_a_q;
    assign w_tok[0].k   = r_k_q;
    assign w_acc[TILE]  = '0;

    for (genvar g = 0; g < TILE; g++) begin : g_cell
        gte_mac_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (clear),
            .i_shift    (shift),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .i_acc      (w_acc[g+1]),
            .o_acc      (w_acc[g]),
            .i_col_tile (r_tcol),
            .i_b_we     (in_acc && (i_req_type == REQ_LOAD_B)
                         && (i_col[TILE_W-1:0] == TILE_W'(g))),
            .i_b_waddr  ({i_row, i_col[DIM_W-1:TILE_W]}),
            .i_b_wdata  (sat16(i_value))
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req_type == REQ_LOAD_A)) begin
            r_a_mem[{i_row, i_col}] <= sat16(i_value);
        end
        r_a_q <= r_a_mem[{r_trow, r_i, r_k[DIM_W-1:0]}];
        r_k_q <= r_k[DIM_W-1:0];
        if (in_acc && (i_req_type == REQ_LOAD_C)) begin
            r_c_mem[{i_row, i_col}] <= i_value;
        end else if ((r_state == S_EPI_OUT) && out_free) begin
            r_c_mem[c_addr] <= sat_sum;
        end
        if (r_state == S_EPI_RD) begin
            r_c_q   <= r_c_mem[c_addr];
            r_acc_q <= w_acc[0];
        end
        r_pa <= r_alpha * r_acc_q;
        r_pb <= r_beta * r_c_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= 16'sd256;
            r_beta      <= '0;
            r_row_tiles <= 4'd8;
            r_col_tiles <= 4'd8;
            r_inner     <= 7'd64;
            r_trow      <= '0;
            r_tcol      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_feed_q    <= 1'b0;
            r_out_valid <= 1'b0;
            o_out_row   <= '0;
            o_out_col   <= '0;
            o_result    <= '0;
            o_last      <= 1'b0;
            o_status    <= 1'b0;
        end else begin
            r_feed_q <= (r_state == S_FEED);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ALPHA:     r_alpha     <= i_cfg_data[15:0];
                    CFG_BETA:      r_beta      <= i_cfg_data[15:0];
                    CFG_ROW_TILES: r_row_tiles <= i_cfg_data[3:0];
                    CFG_COL_TILES: r_col_tiles <= i_cfg_data[3:0];
                    CFG_INNER:     r_inner     <= i_cfg_data[KK_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (clear) begin
                        r_trow <= i_row[TIDX_W-1:0];
                        r_tcol <= i_col[TIDX_W-1:0];
                        r_i    <= '0;
                        r_k    <= '0;
                        r_cnt  <= '0;
                        if ((i_row >= 6'(rt)) || (i_col >= 6'(ct))) begin
                            r_state <= S_ERR;
                        end else if (kk == '0) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_state <= S_FEED;
                        end
                    end
                end
                S_FEED: begin
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == kk) begin
                        r_cnt   <= '0;
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == FLUSH_W'(FLUSH_CYCLES - 1)) begin
                        r_j     <= '0;
                        r_state <= S_EPI_RD;
                    end
                end
                S_EPI_RD: begin
                    r_state <= S_EPI_MUL;
                end
                S_EPI_MUL: begin
                    r_state <= S_EPI_OUT;
                end
                S_EPI_OUT: begin
                    if (out_free) begin
                        o_out_row   <= {r_trow, r_i};
                        o_out_col   <= {r_tcol, r_j};
                        o_result    <= sat_sum;
                        o_last      <= (&r_i) && (&r_j);
                        o_status    <= 1'b0;
                        r_j         <= r_j + 1'b1;
                        if (&r_j) begin
                            r_i   <= r_i + 1'b1;
                            r_k   <= '0;
                            r_cnt <= '0;
                            if (&r_i) begin
                                r_state <= S_IDLE;
                            end else if (kk == '0) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_state <= S_FEED;
                            end
                        end else begin
                            r_state <= S_EPI_RD;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        o_out_row   <= '0;
                        o_out_col   <= '0;
                        o_result    <= '0;
                        o_last      <= 1'b1;
                        o_status    <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_last && (o_result == 32'sd0)))
        else $error("error word without last or with nonzero result");

    a_chain_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPI_RD) |-> (!w_tok[TILE].vld && !r_feed_q))
        else $error("accumulators read while the cell chain still carries words");

    a_feed_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEED) |=> ((r_state == S_FEED) || (r_state == S_FLUSH)))
        else $error("feed phase left without a flush");

endmodule

`default_nettype wire

/* hw/rtl/gte_mac_cell.sv */
// ----------------------------------------------------------------------------
// gte_mac_cell
// One multiply-accumulate cell: holds a bank of B, passes the A word on.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_mac_cell (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_clear,
    input  wire logic                                  i_shift,
    input  wire gte_pkg::t_tok                         i_tok,
    output gte_pkg::t_tok                              o_tok,
    input  wire logic signed [gte_pkg::ACC_W-1:0]      i_acc,
    output logic signed [gte_pkg::ACC_W-1:0]           o_acc,
    input  wire logic [gte_pkg::TIDX_W-1:0]            i_col_tile,
    input  wire logic                                  i_b_we,
    input  wire logic [gte_pkg::BANK_ADDR_W-1:0]       i_b_waddr,
    input  wire logic signed [gte_pkg::ELEM_W-1:0]     i_b_wdata
);
    import gte_pkg::*;

    logic signed [ELEM_W-1:0]   r_bank [MAX_DIM*TILES];
    t_tok                       r_tok;
    logic signed [ELEM_W-1:0]   r_b;
    logic signed [2*ELEM_W-1:0] r_prod;
    logic                       r_pv;
    logic signed [ACC_W-1:0]    r_acc;

    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_bank[i_b_waddr] <= i_b_wdata;
        end
        if (i_tok.vld) begin
            r_b <= r_bank[{i_tok.k, i_col_tile}];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.a <= i_tok.a;
        r_tok.k <= i_tok.k;
        r_prod  <= r_tok.a * r_b;
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
            r_pv      <= 1'b0;
            r_acc     <= '0;
        end else begin
            r_tok.vld <= i_tok.vld;
            r_pv      <= r_tok.vld;
            if (i_clear) begin
                r_acc <= '0;
            end else if (i_shift) begin
                r_acc <= i_acc;
            end else if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

`default_nettype wire
